FILE: design/olx_pkg.sv
`timescale 1ns / 1ps

package olx_pkg;

	// Channel payloads
	typedef struct packed {
		logic [7:0]  byte_value;
		logic [19:0] byte_line;
		logic [15:0] byte_column;
		logic        last_byte;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  token_code;
		logic [1:0]  error_code;
		logic [7:0]  passed_byte;
		logic [19:0] token_line;
		logic [15:0] token_column;
		logic        end_of_run;
	} out_item_t;

	// Scanner state
	typedef struct packed {
		logic [2:0]  scan_mode;
		logic [7:0]  pending_byte;
		logic [19:0] pending_line;
		logic [15:0] pending_column;
		logic        error_latched;
	} scan_state_t;

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_PEND  = 3'd1;
	localparam logic [2:0] MODE_LINE  = 3'd2;
	localparam logic [2:0] MODE_BLOCK = 3'd3;
	localparam logic [2:0] MODE_BSTAR = 3'd4;

	localparam scan_state_t STATE_RESET = '{
		scan_mode: MODE_IDLE, pending_byte: 8'd0, pending_line: 20'd0,
		pending_column: 16'd0, error_latched: 1'b0};

	// Error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_PIPE  = 2'd1;
	localparam logic [1:0] ERR_BLOCK = 2'd2;

	// Token field of an error item
	localparam logic [4:0] ERR_TOKEN = 5'd0;

	// Token codes
	localparam logic [4:0] TK_PLUS       = 5'd0;
	localparam logic [4:0] TK_PLUSPLUS   = 5'd1;
	localparam logic [4:0] TK_MINUS      = 5'd2;
	localparam logic [4:0] TK_MINUSMINUS = 5'd3;
	localparam logic [4:0] TK_STAR       = 5'd4;
	localparam logic [4:0] TK_SLASH      = 5'd5;
	localparam logic [4:0] TK_PERCENT    = 5'd6;
	localparam logic [4:0] TK_CARET      = 5'd7;
	localparam logic [4:0] TK_QUESTION   = 5'd8;
	localparam logic [4:0] TK_AMP        = 5'd9;
	localparam logic [4:0] TK_AMPAMP     = 5'd10;
	localparam logic [4:0] TK_PIPEPIPE   = 5'd11;
	localparam logic [4:0] TK_BANG       = 5'd12;
	localparam logic [4:0] TK_BANGEQ     = 5'd13;
	localparam logic [4:0] TK_EQUAL      = 5'd14;
	localparam logic [4:0] TK_EQEQ       = 5'd15;
	localparam logic [4:0] TK_LESS       = 5'd16;
	localparam logic [4:0] TK_LESSEQ     = 5'd17;
	localparam logic [4:0] TK_GREATER    = 5'd18;
	localparam logic [4:0] TK_GREATEREQ  = 5'd19;
	localparam logic [4:0] TK_LPAREN     = 5'd20;
	localparam logic [4:0] TK_RPAREN     = 5'd21;
	localparam logic [4:0] TK_LBRACE     = 5'd22;
	localparam logic [4:0] TK_RBRACE     = 5'd23;
	localparam logic [4:0] TK_LBRACKET   = 5'd24;
	localparam logic [4:0] TK_RBRACKET   = 5'd25;
	localparam logic [4:0] TK_COLON      = 5'd26;
	localparam logic [4:0] TK_COMMA      = 5'd27;
	localparam logic [4:0] TK_SEMICOLON  = 5'd28;
	localparam logic [4:0] TK_DOT        = 5'd29;
	localparam logic [4:0] TK_PASS       = 5'd30;

	// Characters
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LESS  = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// Output queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// Code of a byte on its own; passthrough when it is no operator
	function automatic logic [4:0] single_code(input logic [7:0] c);
		logic [4:0] r;
		case (c)
			CH_PLUS:  r = TK_PLUS;
			CH_MINUS: r = TK_MINUS;
			CH_STAR:  r = TK_STAR;
			CH_SLASH: r = TK_SLASH;
			8'h25:    r = TK_PERCENT;
			8'h5E:    r = TK_CARET;
			8'h3F:    r = TK_QUESTION;
			CH_AMP:   r = TK_AMP;
			CH_BANG:  r = TK_BANG;
			CH_EQ:    r = TK_EQUAL;
			CH_LESS:  r = TK_LESS;
			CH_GT:    r = TK_GREATER;
			8'h28:    r = TK_LPAREN;
			8'h29:    r = TK_RPAREN;
			8'h7B:    r = TK_LBRACE;
			8'h7D:    r = TK_RBRACE;
			8'h5B:    r = TK_LBRACKET;
			8'h5D:    r = TK_RBRACKET;
			8'h3A:    r = TK_COLON;
			8'h2C:    r = TK_COMMA;
			8'h3B:    r = TK_SEMICOLON;
			8'h2E:    r = TK_DOT;
			default:  r = TK_PASS;
		endcase
		return r;
	endfunction

	function automatic logic may_pair(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_AMP || c == CH_PIPE ||
			c == CH_BANG || c == CH_EQ || c == CH_LESS || c == CH_GT ||
			c == CH_SLASH;
	endfunction

	function automatic logic pair_hit(input logic [7:0] p, input logic [7:0] c);
		return (p == CH_PLUS && c == CH_PLUS) || (p == CH_MINUS && c == CH_MINUS) ||
			(p == CH_AMP && c == CH_AMP) || (p == CH_PIPE && c == CH_PIPE) ||
			(c == CH_EQ && (p == CH_BANG || p == CH_EQ || p == CH_LESS ||
			p == CH_GT));
	endfunction

	function automatic logic [4:0] pair_code(input logic [7:0] p);
		logic [4:0] r;
		case (p)
			CH_PLUS:  r = TK_PLUSPLUS;
			CH_MINUS: r = TK_MINUSMINUS;
			CH_AMP:   r = TK_AMPAMP;
			CH_PIPE:  r = TK_PIPEPIPE;
			CH_BANG:  r = TK_BANGEQ;
			CH_EQ:    r = TK_EQEQ;
			CH_LESS:  r = TK_LESSEQ;
			default:  r = TK_GREATEREQ;
		endcase
		return r;
	endfunction

	function automatic out_item_t make_item(input logic [4:0] code,
			input logic [1:0] err, input logic [7:0] b,
			input logic [19:0] line, input logic [15:0] col);
		out_item_t r;
		r.token_code   = code;
		r.error_code   = err;
		r.passed_byte  = b;
		r.token_line   = line;
		r.token_column = col;
		r.end_of_run   = 1'b0;
		return r;
	endfunction

	// One-character token for a byte, with the byte itself on passthrough
	function automatic out_item_t single_item(input logic [7:0] c,
			input logic [19:0] line, input logic [15:0] col);
		logic [4:0] code;
		code = single_code(c);
		return make_item(code, ERR_NONE, (code == TK_PASS) ? c : 8'd0, line, col);
	endfunction

endpackage

FILE: design/olx_step.sv
`timescale 1ns / 1ps

module olx_step (
	input  olx_pkg::scan_state_t cur,
	input  olx_pkg::in_item_t    item,
	output olx_pkg::scan_state_t nxt,
	output logic [1:0]           push_n,
	output olx_pkg::out_item_t   res0,
	output olx_pkg::out_item_t   res1
);
	import olx_pkg::*;

	logic [7:0] c;
	logic [1:0] n;
	out_item_t  tail;
	logic       tail_hit;

	assign c = item.byte_value;

	always_comb begin
		nxt      = cur;
		n        = 2'd0;
		res0     = '0;
		res1     = '0;
		tail     = '0;
		tail_hit = 1'b0;

		if (cur.error_latched) begin
			// drop everything until the last byte
			if (item.last_byte) begin
				nxt = STATE_RESET;
			end
		end else begin
			case (cur.scan_mode)
				MODE_LINE: begin
					if (c == CH_NL) begin
						nxt.scan_mode = MODE_IDLE;
					end
				end
				MODE_BLOCK: begin
					if (c == CH_STAR) begin
						nxt.scan_mode = MODE_BSTAR;
					end
				end
				MODE_BSTAR: begin
					if (c == CH_SLASH) begin
						nxt.scan_mode = MODE_IDLE;
					end else if (c != CH_STAR) begin
						nxt.scan_mode = MODE_BLOCK;
					end
				end
				MODE_PEND: begin
					if (cur.pending_byte == CH_SLASH && c == CH_SLASH) begin
						nxt.scan_mode = MODE_LINE;
					end else if (cur.pending_byte == CH_SLASH && c == CH_STAR) begin
						// keep the opening slash position for the error report
						nxt.scan_mode = MODE_BLOCK;
					end else if (pair_hit(cur.pending_byte, c)) begin
						res0 = make_item(pair_code(cur.pending_byte), ERR_NONE, 8'd0,
							cur.pending_line, cur.pending_column);
						n = 2'd1;
						nxt.scan_mode = MODE_IDLE;
					end else if (cur.pending_byte == CH_PIPE) begin
						// lone pipe: report and latch, drop this byte
						res0 = make_item(ERR_TOKEN, ERR_PIPE, 8'd0,
							cur.pending_line, cur.pending_column);
						n = 2'd1;
						nxt.scan_mode = MODE_IDLE;
						nxt.error_latched = 1'b1;
					end else begin
						// flush held byte, then start on the new one
						res0 = single_item(cur.pending_byte,
							cur.pending_line, cur.pending_column);
						n = 2'd1;
						if (may_pair(c)) begin
							nxt.scan_mode      = MODE_PEND;
							nxt.pending_byte   = c;
							nxt.pending_line   = item.byte_line;
							nxt.pending_column = item.byte_column;
						end else begin
							nxt.scan_mode = MODE_IDLE;
							res1 = single_item(c, item.byte_line, item.byte_column);
							n = 2'd2;
						end
					end
				end
				default: begin
					if (may_pair(c)) begin
						nxt.scan_mode      = MODE_PEND;
						nxt.pending_byte   = c;
						nxt.pending_line   = item.byte_line;
						nxt.pending_column = item.byte_column;
					end else begin
						nxt.scan_mode = MODE_IDLE;
						res0 = single_item(c, item.byte_line, item.byte_column);
						n = 2'd1;
					end
				end
			endcase

			// end of source: flush pending byte (a lone pipe as an error) or report open block comment
			if (item.last_byte) begin
				if (!nxt.error_latched) begin
					if (nxt.scan_mode == MODE_PEND) begin
						tail_hit = 1'b1;
						if (nxt.pending_byte == CH_PIPE) begin
							tail = make_item(ERR_TOKEN, ERR_PIPE, 8'd0,
								nxt.pending_line, nxt.pending_column);
						end else begin
							tail = single_item(nxt.pending_byte,
								nxt.pending_line, nxt.pending_column);
						end
					end else if (nxt.scan_mode == MODE_BLOCK ||
						nxt.scan_mode == MODE_BSTAR) begin
						tail_hit = 1'b1;
						tail = make_item(ERR_TOKEN, ERR_BLOCK, 8'd0,
							nxt.pending_line, nxt.pending_column);
					end
				end
				if (tail_hit) begin
					if (n == 2'd0) begin
						res0 = tail;
					end else begin
						res1 = tail;
					end
					n = n + 2'd1;
				end
				nxt = STATE_RESET;
			end
		end

		// mark the last result of this byte
		if (n == 2'd1) begin
			res0.end_of_run = 1'b1;
		end else if (n == 2'd2) begin
			res1.end_of_run = 1'b1;
		end
	end

	assign push_n = n;

endmodule

FILE: design/olx_outq.sv
`timescale 1ns / 1ps

module olx_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  olx_pkg::out_item_t res0,
	input  olx_pkg::out_item_t res1,
	output logic               room,
	output logic               token_valid,
	input  logic               token_stall,
	output olx_pkg::out_item_t token_item
);
	import olx_pkg::*;

	out_item_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            pop;

	assign token_valid = (count_q != '0);
	assign token_item  = mem_q[rd_ptr_q];
	assign pop         = token_valid && !token_stall;
	// room for two results from the next byte
	assign room        = (count_q <= (Q_AW+1)'(Q_DEPTH - 2));

	// write results in order
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_q + Q_AW'(1)] <= res1;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("output queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("push without room");

	a_push_range: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd3)
		else $error("more than two results from one byte");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> count_q == $past(count_q) - (Q_AW+1)'(1))
		else $error("occupancy did not drop on pop");

endmodule

FILE: design/operator_and_comment_lexer.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload                    Role
// byte      byte_valid / byte_stall    byte_item  (in_item_t)     source bytes in
// token     token_valid / token_stall  token_item (out_item_t)    tokens and errors out
//
// A byte is scanned in the cycle it is accepted; its zero to two results land in a
// four-entry output queue and can leave from the next cycle, one per unstalled cycle.
// Sustained rate is one byte per unstalled cycle while bytes give at most one result
// each; the queue's single read port sets that limit, so byte_stall rises when fewer
// than two slots are free. Reset is asynchronous and clears scanner state and queue
// occupancy. A token stall backs up into byte_stall once three results are waiting.

module operator_and_comment_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  olx_pkg::in_item_t  byte_item,
	output logic               token_valid,
	input  logic               token_stall,
	output olx_pkg::out_item_t token_item
);
	import olx_pkg::*;

	scan_state_t state_q;
	scan_state_t state_nxt;
	logic [1:0]  step_n;
	logic [1:0]  push_n;
	out_item_t   res0;
	out_item_t   res1;
	logic        room;
	logic        accept;

	assign byte_stall = !room;
	assign accept     = byte_valid && room;
	assign push_n     = accept ? step_n : 2'd0;

	olx_step u_step (
		.cur    (state_q),
		.item   (byte_item),
		.nxt    (state_nxt),
		.push_n (step_n),
		.res0   (res0),
		.res1   (res1)
	);

	olx_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (push_n),
		.res0        (res0),
		.res1        (res1),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

	// hold scanner state between accepted items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_item.last_byte |=> state_q.scan_mode == MODE_IDLE &&
		!state_q.error_latched)
		else $error("scanner not reset after last byte");

	a_latch_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.error_latched |-> step_n == 2'd0)
		else $error("result while error latched");

	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_item))
		else $error("token item changed while stalled");

endmodule

FILE: sim/tb_operator_and_comment_lexer.sv
`timescale 1ns / 1ps

module tb_operator_and_comment_lexer;
	import olx_pkg::*;

	localparam int RANDOM_ITEMS = 2000;

	// Directed row: one byte, and optionally the items it must give
	typedef struct packed {
		logic [7:0]  ch;
		logic [19:0] line;
		logic [15:0] col;
		logic        last;
		logic        typed;
		logic [1:0]  n;
		out_item_t   want;
	} probe_t;

	localparam probe_t PROBES [28] = '{
		// first byte after reset, position zero
		'{"(", 20'd0, 16'd0, 1'b0, 1'b1, 2'd1,
			'{TK_LPAREN, ERR_NONE, 8'h00, 20'd0, 16'd0, 1'b1}},
		// byte and position at their top values
		'{8'hFF, 20'hFFFFF, 16'hFFFF, 1'b0, 1'b1, 2'd1,
			'{TK_PASS, ERR_NONE, 8'hFF, 20'hFFFFF, 16'hFFFF, 1'b1}},
		'{8'h00, 20'd1, 16'd1, 1'b0, 1'b1, 2'd1,
			'{TK_PASS, ERR_NONE, 8'h00, 20'd1, 16'd1, 1'b1}},
		// pair, then a held byte resolved by a non-partner
		'{CH_PLUS, 20'd1, 16'd2, 1'b0, 1'b0, 2'd0, '0},
		'{CH_PLUS, 20'd1, 16'd3, 1'b0, 1'b0, 2'd0, '0},
		'{CH_MINUS, 20'd1, 16'd4, 1'b0, 1'b0, 2'd0, '0},
		'{"x", 20'd1, 16'd5, 1'b0, 1'b0, 2'd0, '0},
		// line comment through its newline
		'{CH_SLASH, 20'd1, 16'd6, 1'b0, 1'b0, 2'd0, '0},
		'{CH_SLASH, 20'd1, 16'd7, 1'b0, 1'b0, 2'd0, '0},
		'{"a", 20'd1, 16'd8, 1'b0, 1'b0, 2'd0, '0},
		'{CH_NL, 20'd1, 16'd9, 1'b0, 1'b0, 2'd0, '0},
		// block comment whose opener star cannot close it
		'{CH_SLASH, 20'd2, 16'd0, 1'b0, 1'b0, 2'd0, '0},
		'{CH_STAR, 20'd2, 16'd1, 1'b0, 1'b0, 2'd0, '0},
		'{CH_SLASH, 20'd2, 16'd2, 1'b0, 1'b0, 2'd0, '0},
		'{CH_STAR, 20'd2, 16'd3, 1'b0, 1'b0, 2'd0, '0},
		'{CH_STAR, 20'd2, 16'd4, 1'b0, 1'b0, 2'd0, '0},
		'{CH_SLASH, 20'd2, 16'd5, 1'b0, 1'b0, 2'd0, '0},
		'{CH_BANG, 20'd2, 16'd6, 1'b0, 1'b0, 2'd0, '0},
		'{CH_EQ, 20'd2, 16'd7, 1'b0, 1'b0, 2'd0, '0},
		'{CH_PIPE, 20'd2, 16'd8, 1'b0, 1'b0, 2'd0, '0},
		'{CH_PIPE, 20'd2, 16'd9, 1'b0, 1'b0, 2'd0, '0},
		// lone pipe, then everything dropped up to the last byte
		'{CH_PIPE, 20'd2, 16'd10, 1'b0, 1'b1, 2'd0, '0},
		'{"a", 20'd2, 16'd11, 1'b0, 1'b1, 2'd1,
			'{ERR_TOKEN, ERR_PIPE, 8'h00, 20'd2, 16'd10, 1'b1}},
		'{"b", 20'd2, 16'd12, 1'b1, 1'b1, 2'd0, '0},
		// block comment still open at the last byte
		'{CH_SLASH, 20'd3, 16'd0, 1'b0, 1'b0, 2'd0, '0},
		'{CH_STAR, 20'd3, 16'd1, 1'b0, 1'b0, 2'd0, '0},
		'{"x", 20'd3, 16'd2, 1'b1, 1'b1, 2'd1,
			'{ERR_TOKEN, ERR_BLOCK, 8'h00, 20'd3, 16'd0, 1'b1}},
		// held byte flushed by the last byte
		'{CH_LESS, 20'd4, 16'd0, 1'b1, 1'b1, 2'd1,
			'{TK_LESS, ERR_NONE, 8'h00, 20'd4, 16'd0, 1'b1}}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      token_valid;
	logic      token_stall = 1'b0;
	out_item_t token_item;

	int tx_idle_pct = 32;
	int rx_idle_pct = 49;
	int mismatches = 0;
	int sent = 0;

	scan_state_t scan_st = STATE_RESET;
	out_item_t   step_tokens[$];
	out_item_t   tokens_due[$];
	logic [7:0]  src[$];

	string op_chars = "+-*/%^?&!=<>(){}[]:,;.|";
	string duos [8] = '{"++", "--", "&&", "||", "!=", "==", "<=", ">="};

	operator_and_comment_lexer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_item (token_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Append to this byte's items, the expected stream and the source text
	function automatic void add_step_token(input out_item_t t);
		step_tokens = {step_tokens, t};
	endfunction

	function automatic void add_due(input out_item_t t);
		tokens_due = {tokens_due, t};
	endfunction

	function automatic void add_src(input logic [7:0] c);
		src = {src, c};
	endfunction

	function automatic out_item_t mk_token(input logic [4:0] code, input logic [1:0] err,
			input logic [7:0] b, input logic [19:0] line, input logic [15:0] col);
		out_item_t t;
		t.token_code   = code;
		t.error_code   = err;
		t.passed_byte  = b;
		t.token_line   = line;
		t.token_column = col;
		t.end_of_run   = 1'b0;
		return t;
	endfunction

	// One-character token, or the byte itself passed through
	function automatic out_item_t token_of(input logic [7:0] c, input logic [19:0] line,
			input logic [15:0] col);
		logic [4:0] code;
		case (c)
			CH_PLUS:  code = TK_PLUS;
			CH_MINUS: code = TK_MINUS;
			CH_STAR:  code = TK_STAR;
			CH_SLASH: code = TK_SLASH;
			"%":      code = TK_PERCENT;
			"^":      code = TK_CARET;
			"?":      code = TK_QUESTION;
			CH_AMP:   code = TK_AMP;
			CH_BANG:  code = TK_BANG;
			CH_EQ:    code = TK_EQUAL;
			CH_LESS:  code = TK_LESS;
			CH_GT:    code = TK_GREATER;
			"(":      code = TK_LPAREN;
			")":      code = TK_RPAREN;
			"{":      code = TK_LBRACE;
			"}":      code = TK_RBRACE;
			"[":      code = TK_LBRACKET;
			"]":      code = TK_RBRACKET;
			":":      code = TK_COLON;
			",":      code = TK_COMMA;
			";":      code = TK_SEMICOLON;
			".":      code = TK_DOT;
			default:  code = TK_PASS;
		endcase
		return mk_token(code, ERR_NONE, (code == TK_PASS) ? c : 8'h00, line, col);
	endfunction

	// Hold a possible pair start, else emit the byte's token
	function automatic void begin_token(input in_item_t b);
		if (b.byte_value inside {CH_PLUS, CH_MINUS, CH_AMP, CH_PIPE, CH_BANG, CH_EQ,
				CH_LESS, CH_GT, CH_SLASH}) begin
			scan_st.scan_mode      = MODE_PEND;
			scan_st.pending_byte   = b.byte_value;
			scan_st.pending_line   = b.byte_line;
			scan_st.pending_column = b.byte_column;
		end else begin
			scan_st.scan_mode = MODE_IDLE;
			add_step_token(token_of(b.byte_value, b.byte_line, b.byte_column));
		end
	endfunction

	// Resolve the held byte alone; a lone pipe latches the error
	function automatic void flush_held();
		if (scan_st.pending_byte == CH_PIPE) begin
			add_step_token(mk_token(ERR_TOKEN, ERR_PIPE, 8'h00,
				scan_st.pending_line, scan_st.pending_column));
			scan_st.error_latched = 1'b1;
		end else begin
			add_step_token(token_of(scan_st.pending_byte, scan_st.pending_line,
				scan_st.pending_column));
		end
		scan_st.scan_mode = MODE_IDLE;
	endfunction

	// Advance the scanner by one byte; its items land in step_tokens
	function automatic bit lex_step(input in_item_t b);
		logic [7:0] c;
		logic [4:0] code;
		c = b.byte_value;
		step_tokens.delete();
		if (scan_st.error_latched) begin
			if (b.last_byte)
				scan_st = STATE_RESET;
			return 1'b1;
		end
		case (scan_st.scan_mode)
			MODE_LINE: begin
				if (c == CH_NL)
					scan_st.scan_mode = MODE_IDLE;
			end
			MODE_BLOCK: begin
				if (c == CH_STAR)
					scan_st.scan_mode = MODE_BSTAR;
			end
			MODE_BSTAR: begin
				if (c == CH_SLASH)
					scan_st.scan_mode = MODE_IDLE;
				else if (c != CH_STAR)
					scan_st.scan_mode = MODE_BLOCK;
			end
			MODE_PEND: begin
				if (scan_st.pending_byte == CH_SLASH && c == CH_SLASH) begin
					scan_st.scan_mode = MODE_LINE;
				end else if (scan_st.pending_byte == CH_SLASH && c == CH_STAR) begin
					scan_st.scan_mode = MODE_BLOCK;
				end else begin
					code = TK_PASS;
					case (scan_st.pending_byte)
						CH_PLUS:  if (c == CH_PLUS) code = TK_PLUSPLUS;
						CH_MINUS: if (c == CH_MINUS) code = TK_MINUSMINUS;
						CH_AMP:   if (c == CH_AMP) code = TK_AMPAMP;
						CH_PIPE:  if (c == CH_PIPE) code = TK_PIPEPIPE;
						CH_BANG:  if (c == CH_EQ) code = TK_BANGEQ;
						CH_EQ:    if (c == CH_EQ) code = TK_EQEQ;
						CH_LESS:  if (c == CH_EQ) code = TK_LESSEQ;
						CH_GT:    if (c == CH_EQ) code = TK_GREATEREQ;
						default: ;
					endcase
					if (code != TK_PASS) begin
						add_step_token(mk_token(code, ERR_NONE, 8'h00,
							scan_st.pending_line, scan_st.pending_column));
						scan_st.scan_mode = MODE_IDLE;
					end else begin
						flush_held();
						if (!scan_st.error_latched)
							begin_token(b);
					end
				end
			end
			default: begin_token(b);
		endcase
		// Close the source: flush, report an open block comment, clear all
		if (b.last_byte) begin
			if (!scan_st.error_latched) begin
				if (scan_st.scan_mode == MODE_PEND)
					flush_held();
				else if (scan_st.scan_mode == MODE_BLOCK || scan_st.scan_mode == MODE_BSTAR)
					add_step_token(mk_token(ERR_TOKEN, ERR_BLOCK, 8'h00,
						scan_st.pending_line, scan_st.pending_column));
			end
			scan_st = STATE_RESET;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].end_of_run = 1'b1;
		return 1'b0;
	endfunction

	// Offer one item with random gaps ahead of it; return once accepted
	task automatic send_byte(input in_item_t b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
	endtask

	task automatic compare_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	// Check each accepted token item against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (token_valid && !token_stall) begin
				if (tokens_due.size() == 0) begin
					mismatches++;
					$display("%0t: token item expected none actual %h", $time, token_item);
				end else begin
					want = tokens_due.pop_front();
					compare_field("token_code", want.token_code, token_item.token_code);
					compare_field("error_code", want.error_code, token_item.error_code);
					compare_field("passed_byte", want.passed_byte, token_item.passed_byte);
					compare_field("token_line", want.token_line, token_item.token_line);
					compare_field("token_column", want.token_column, token_item.token_column);
					compare_field("end_of_run", want.end_of_run, token_item.end_of_run);
				end
			end
			token_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	initial begin
		in_item_t    b;
		probe_t      p;
		logic [19:0] line;
		logic [15:0] col;
		int          len;
		int          k;
		bit          dropped;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		for (int i = 0; i < $size(PROBES); i++) begin
			p = PROBES[i];
			b = '{p.ch, p.line, p.col, p.last};
			send_byte(b);
			dropped = lex_step(b);
			if (p.typed) begin
				if (p.n != 0)
					add_due(p.want);
			end else begin
				foreach (step_tokens[j])
					add_due(step_tokens[j]);
			end
		end

		// Random sources: mostly operators, pairs and comments, some noise
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else if (sent >= RANDOM_ITEMS / 3) begin
				tx_idle_pct = 49;
				rx_idle_pct = 32;
			end
			len = $urandom_range(1, 40);
			src.delete();
			while (src.size() < len) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: add_src(op_chars[$urandom_range(0, op_chars.len() - 1)]);
					4: add_src(8'($urandom_range(8'h61, 8'h7A)));
					5: add_src(8'($urandom_range(0, 255)));
					6: add_src($urandom_range(0, 1) ? CH_NL : 8'h20);
					7: begin
						add_src(CH_SLASH);
						add_src(CH_SLASH);
						k = $urandom_range(0, 4);
						repeat (k) add_src(8'($urandom_range(0, 255)));
						add_src(CH_NL);
					end
					8: begin
						add_src(CH_SLASH);
						add_src(CH_STAR);
						k = $urandom_range(0, 5);
						repeat (k) begin
							case ($urandom_range(0, 3))
								0: add_src(CH_STAR);
								1: add_src(CH_SLASH);
								default: add_src(8'($urandom_range(0, 255)));
							endcase
						end
						add_src(CH_STAR);
						add_src(CH_SLASH);
					end
					default: begin
						k = $urandom_range(0, 7);
						add_src(duos[k][0]);
						add_src(duos[k][1]);
					end
				endcase
			end
			// cut to length so comments may stay open at the last byte
			while (src.size() > len)
				void'(src.pop_back());
			line = 20'($urandom());
			col  = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 80));
			for (int i = 0; i < len; i++) begin
				b = '{src[i], line, col, i == len - 1};
				send_byte(b);
				dropped = lex_step(b);
				foreach (step_tokens[j])
					add_due(step_tokens[j]);
				if (!dropped)
					sent++;
				if (src[i] == CH_NL) begin
					line++;
					col = 16'd0;
				end else begin
					col++;
				end
			end
		end
		byte_valid <= 1'b0;

		// Drain, then allow for stray items
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
